FILE: rtl/lsi_pkg.sv
// Package for the line-start index and lookup block.
// Holds the fixed field widths, opcode and byte codes, and the sequencer state type.
// No dependencies.
`default_nettype none

package lsi_pkg;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int QPOS_W   = 20;
    localparam int LINE_W   = 12;
    localparam int COL_W    = 20;

    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } lsi_state_t;

endpackage

`default_nettype wire

FILE: rtl/lsi_if.sv
// Request and result channel interfaces for the line-start index block.
// Each carries valid, ready and the payload fields; widths come from lsi_pkg.
`default_nettype none

interface lsi_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsi_pkg::OPCODE_W-1:0]  opcode;
    logic [lsi_pkg::BYTE_W-1:0]    text_byte;
    logic [lsi_pkg::QPOS_W-1:0]    query_pos;

    modport source (output valid, output opcode, output text_byte, output query_pos,
                    input ready);
    modport sink   (input valid, input opcode, input text_byte, input query_pos,
                    output ready);
endinterface

interface lsi_out_if;
    logic                        valid;
    logic                        ready;
    logic [lsi_pkg::LINE_W-1:0]  line_number;
    logic [lsi_pkg::COL_W-1:0]   column_number;
    logic                        past_end;
    logic                        overflowed;

    modport source (output valid, output line_number, output column_number,
                    output past_end, output overflowed, input ready);
    modport sink   (input valid, input line_number, input column_number,
                    input past_end, input overflowed, output ready);
endinterface

`default_nettype wire

FILE: rtl/lsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line-start table. No dependencies.
`default_nettype none

module lsi_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/line_start_index_and_lookup_top.sv
// Top level of the line-start index and lookup block.
// Depends on lsi_pkg, lsi_in_if, lsi_out_if and lsi_ram.
`default_nettype none

// Source bytes and clear requests are taken while idle and produce no result.
// A position query is accepted, runs a binary search over the line starts of
// the L closed lines, one step per RAM read, and then loads the result register
// once it is free; a full table holds 4095 closed lines. A query past the end
// of the source skips the search. The search step is bound by the single read
// port of the line-start RAM, which returns one entry per cycle. The block takes
// no new request while a query is in its search or waits for a busy output
// register. A result waits in the output register while bytes and clears keep
// flowing. The table needs no clearing after reset: only entries below the
// closed-line count are ever read.
module line_start_index_and_lookup_top #(
    parameter int MAX_LINES = 4096,
    parameter int POS_BITS  = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lsi_in_if.sink    in_ch,
    lsi_out_if.source out_ch
);

    import lsi_pkg::*;

    localparam int LINE_BITS = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_BITS  = LINE_BITS + 1;

    lsi_state_t            state_reg, state_next;
    logic [LINE_BITS-1:0]  closed_reg, closed_next;
    logic [POS_BITS-1:0]   open_start_reg, open_start_next;
    logic [POS_BITS-1:0]   byte_total_reg, byte_total_next;
    logic                  ovf_reg, ovf_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  past_reg, past_next;
    logic [LINE_BITS-1:0]  left_reg, left_next;
    logic [CNT_BITS-1:0]   right_reg, right_next;
    logic [LINE_BITS-1:0]  mid_reg, mid_next;
    logic [POS_BITS-1:0]   left_entry_reg, left_entry_next;

    logic                  out_valid_reg, out_valid_next;
    logic [LINE_W-1:0]     line_out_reg, line_out_next;
    logic [COL_W-1:0]      col_out_reg, col_out_next;
    logic                  past_out_reg, past_out_next;
    logic                  ovf_out_reg, ovf_out_next;

    logic                  accept;
    logic [POS_BITS-1:0]   pos_in;
    logic                  total_full;
    logic                  table_full;
    logic                  wr_en;
    logic [POS_BITS-1:0]   rd_data;
    logic [POS_BITS-1:0]   entry;
    logic                  go_right;
    logic [LINE_BITS-1:0]  step_left;
    logic [CNT_BITS-1:0]   step_right;
    logic [POS_BITS-1:0]   step_entry;
    logic [LINE_BITS-1:0]  sel_left;
    logic [CNT_BITS-1:0]   sel_right;
    logic [CNT_BITS-1:0]   mid_sum;
    logic [LINE_BITS-1:0]  next_mid;
    logic                  more_steps;
    logic                  out_free;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign pos_in      = POS_BITS'(in_ch.query_pos);
    assign total_full  = (byte_total_reg == {POS_BITS{1'b1}});
    assign table_full  = (closed_reg == LINE_BITS'(MAX_LINES - 1));
    assign wr_en       = accept && (in_ch.opcode == OP_BYTE) && !total_full &&
                         (in_ch.text_byte == NEWLINE_BYTE) && !table_full;

    lsi_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (MAX_LINES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (closed_reg),
        .wr_data (open_start_reg),
        .rd_addr (next_mid),
        .rd_data (rd_data)
    );

    // One search step: compare the probed entry, narrow the interval, pick the next probe.
    assign entry      = (mid_reg == closed_reg) ? open_start_reg : rd_data;
    assign go_right   = (entry > pos_reg);
    assign step_left  = go_right ? left_reg : mid_reg;
    assign step_right = go_right ? {1'b0, mid_reg} : right_reg;
    assign step_entry = go_right ? left_entry_reg : entry;

    assign sel_left   = (state_reg == ST_SEARCH) ? step_left : '0;
    assign sel_right  = (state_reg == ST_SEARCH) ? step_right
                                                 : ({1'b0, closed_reg} + CNT_BITS'(1));
    assign mid_sum    = {1'b0, sel_left} + sel_right;
    assign next_mid   = mid_sum[CNT_BITS-1:1];
    assign more_steps = (sel_right > ({1'b0, sel_left} + CNT_BITS'(1)));

    assign out_free   = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next      = state_reg;
        closed_next     = closed_reg;
        open_start_next = open_start_reg;
        byte_total_next = byte_total_reg;
        ovf_next        = ovf_reg;
        pos_next        = pos_reg;
        past_next       = past_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        mid_next        = mid_reg;
        left_entry_next = left_entry_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        line_out_next   = line_out_reg;
        col_out_next    = col_out_reg;
        past_out_next   = past_out_reg;
        ovf_out_next    = ovf_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.opcode)
                        OP_CLEAR:
                        begin
                            closed_next     = '0;
                            open_start_next = '0;
                            byte_total_next = '0;
                            ovf_next        = 1'b0;
                        end
                        OP_BYTE:
                        begin
                            if (total_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                byte_total_next = byte_total_reg + POS_BITS'(1);
                                if (in_ch.text_byte == NEWLINE_BYTE)
                                begin
                                    if (table_full)
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        closed_next     = closed_reg + LINE_BITS'(1);
                                        open_start_next = byte_total_reg + POS_BITS'(1);
                                    end
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            pos_next        = pos_in;
                            past_next       = (pos_in > byte_total_reg);
                            left_next       = '0;
                            right_next      = sel_right;
                            mid_next        = next_mid;
                            left_entry_next = '0;
                            if (!past_next && more_steps)
                            begin
                                state_next = ST_SEARCH;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                left_next       = step_left;
                right_next      = step_right;
                mid_next        = next_mid;
                left_entry_next = step_entry;
                if (!more_steps)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    past_out_next  = past_reg;
                    ovf_out_next   = ovf_reg;
                    if (past_reg)
                    begin
                        line_out_next = '0;
                        col_out_next  = '0;
                    end
                    else
                    begin
                        line_out_next = LINE_W'(left_reg);
                        col_out_next  = COL_W'(pos_reg - left_entry_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            closed_reg     <= '0;
            open_start_reg <= '0;
            byte_total_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            closed_reg     <= closed_next;
            open_start_reg <= open_start_next;
            byte_total_reg <= byte_total_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        past_reg       <= past_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        mid_reg        <= mid_next;
        left_entry_reg <= left_entry_next;
        line_out_reg   <= line_out_next;
        col_out_reg    <= col_out_next;
        past_out_reg   <= past_out_next;
        ovf_out_reg    <= ovf_out_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.line_number   = line_out_reg;
    assign out_ch.column_number = col_out_reg;
    assign out_ch.past_end      = past_out_reg;
    assign out_ch.overflowed    = ovf_out_reg;

endmodule

`default_nettype wire

FILE: rtl/lsi_checker.sv
// Port-level checker for the line-start index block, bound to the top level.
// Depends on lsi_pkg for field widths and opcode codes.
`default_nettype none

module lsi_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [lsi_pkg::OPCODE_W-1:0] opcode,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [lsi_pkg::LINE_W-1:0]   line_number,
    input wire logic [lsi_pkg::COL_W-1:0]    column_number,
    input wire logic                         past_end,
    input wire logic                         overflowed
);

    import lsi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(line_number) && $stable(column_number) &&
                                    $stable(past_end) && $stable(overflowed))
        else $error("stalled result changed");

    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && past_end |-> (line_number == '0) && (column_number == '0))
        else $error("past-end result carries a nonzero line or column");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_QUERY) |=> !in_ready && !out_valid ||
                                                          !in_ready)
        else $error("request taken while a query is in progress");

endmodule

bind line_start_index_and_lookup_top lsi_checker u_lsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .opcode        (in_ch.opcode),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .line_number   (out_ch.line_number),
    .column_number (out_ch.column_number),
    .past_end      (out_ch.past_end),
    .overflowed    (out_ch.overflowed)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for line_start_index_and_lookup_top: random and directed text and queries.
// Checks every lookup result against an in-bench line-start index kept at the block's widths.
// Depends on lsi_pkg and the lsi_in_if / lsi_out_if interfaces.
`timescale 1ns / 100ps

module tb_top;

    import lsi_pkg::*;

    localparam int                  TABLE_DEPTH = 4096;
    localparam logic [QPOS_W-1:0]   POS_LIMIT   = '1;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                  RANDOM_GOAL = 1900;
    localparam int                  SETTLE_CYC  = 20;

    typedef enum logic [1:0] {
        PK_REQUEST,
        PK_DRAIN,
        PK_STEADY_ON,
        PK_STEADY_OFF
    } pend_kind_t;

    typedef struct {
        pend_kind_t            kind;
        logic [OPCODE_W-1:0]   opcode;
        logic [BYTE_W-1:0]     text_byte;
        logic [QPOS_W-1:0]     query_pos;
    } pending_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic              past;
        logic              ovf;
    } location_t;

    logic clk;
    logic rst_n;

    lsi_in_if  in_ch ();
    lsi_out_if out_ch ();

    line_start_index_and_lookup_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // index shadow, updated on accepted requests
    logic [QPOS_W-1:0] start_shadow [TABLE_DEPTH];
    int                lines_closed;
    logic [QPOS_W-1:0] open_start;
    logic [QPOS_W-1:0] bytes_counted;
    logic              overflow_seen;

    location_t expected_locations [$];
    pending_t  pending [$];
    pending_t  on_wire;

    // generator view of the source, used to aim queries
    int gen_total;
    int gen_lines;
    int gen_starts [$];

    int  mismatches;
    int  n_queries, n_past, n_ovf, n_bytes, n_clears;
    bit  drained;
    bit  steady;
    int  burst_left, gap_left, settle;
    logic [15:0] stall_pat;
    int  pat_left;
    logic [3:0] pat_idx;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [QPOS_W-1:0] start_at(input int idx);
        if (idx >= lines_closed)
            return open_start;
        return start_shadow[idx[LINE_W-1:0]];
    endfunction

    function automatic location_t locate_position(input logic [QPOS_W-1:0] pos);
        location_t loc;
        int lo, hi, mid;
        loc = '0;
        if (pos > bytes_counted)
            loc.past = 1'b1;
        else
        begin
            lo = 0;
            hi = lines_closed + 1;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if (start_at(mid) > pos)
                    hi = mid;
                else
                    lo = mid;
            end
            loc.line = lo[LINE_W-1:0];
            loc.col  = pos - start_at(lo);
        end
        loc.ovf = overflow_seen;
        return loc;
    endfunction

    task automatic absorb_request(input pending_t rq);
        location_t loc;
        case (rq.opcode)
            OP_CLEAR:
            begin
                lines_closed  = 0;
                open_start    = '0;
                bytes_counted = '0;
                overflow_seen = 1'b0;
                n_clears++;
            end
            OP_BYTE:
            begin
                n_bytes++;
                if (bytes_counted >= POS_LIMIT)
                    overflow_seen = 1'b1;
                else
                begin
                    if (rq.text_byte == NEWLINE_BYTE)
                    begin
                        if (lines_closed < TABLE_DEPTH - 1)
                        begin
                            start_shadow[lines_closed[LINE_W-1:0]] = open_start;
                            lines_closed++;
                            open_start = bytes_counted + 1'b1;
                        end
                        else
                            overflow_seen = 1'b1;
                    end
                    bytes_counted = bytes_counted + 1'b1;
                end
            end
            OP_QUERY:
            begin
                loc = locate_position(rq.query_pos);
                expected_locations.push_back(loc);
                n_queries++;
                if (loc.past)
                    n_past++;
                if (loc.ovf)
                    n_ovf++;
            end
            default: ;
        endcase
    endtask

    task automatic push_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b,
                                input logic [QPOS_W-1:0] p);
        pending_t rq;
        rq.kind      = PK_REQUEST;
        rq.opcode    = op;
        rq.text_byte = b;
        rq.query_pos = p;
        pending.push_back(rq);
        if (op == OP_CLEAR)
        begin
            gen_total = 0;
            gen_lines = 0;
            gen_starts.delete();
            gen_starts.push_back(0);
        end
        else if (op == OP_BYTE && gen_total < int'(POS_LIMIT))
        begin
            if (b == NEWLINE_BYTE && gen_lines < TABLE_DEPTH - 1)
            begin
                gen_lines++;
                gen_starts.push_back(gen_total + 1);
            end
            gen_total++;
        end
    endtask

    task automatic push_marker(input pend_kind_t k);
        pending_t rq;
        rq.kind      = k;
        rq.opcode    = OP_CLEAR;
        rq.text_byte = '0;
        rq.query_pos = '0;
        pending.push_back(rq);
    endtask

    function automatic logic [QPOS_W-1:0] choose_position();
        int r, p;
        r = $urandom_range(0, 99);
        if (r < 40)
            p = $urandom_range(0, gen_total);
        else if (r < 70)
        begin
            p = gen_starts[$urandom_range(0, gen_starts.size() - 1)] + $urandom_range(0, 2) - 1;
            if (p < 0)
                p = 0;
        end
        else if (r < 85)
            p = gen_total;
        else if (r < 90 || gen_total >= int'(POS_LIMIT))
            p = int'(POS_LIMIT);
        else
            p = gen_total + $urandom_range(1, 5);
        if (p > int'(POS_LIMIT))
            p = int'(POS_LIMIT);
        return p[QPOS_W-1:0];
    endfunction

    // driver: hold the request until accepted, then advance
    always @(posedge clk)
    begin
        logic present;
        logic fire;
        logic scanning;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            steady      = 1'b0;
            burst_left  = 1;
            gap_left    = 0;
            settle      = SETTLE_CYC;
        end
        else
        begin
            fire = in_ch.valid && in_ch.ready;
            if (fire)
                absorb_request(on_wire);
            if (fire || !drained)
                settle = SETTLE_CYC;
            else if (settle != 0)
                settle--;
            if (!(in_ch.valid && !in_ch.ready))
            begin
                present  = 1'b0;
                scanning = 1'b1;
                while (scanning && pending.size() > 0 && pending[0].kind != PK_REQUEST)
                begin
                    case (pending[0].kind)
                        PK_STEADY_ON:
                        begin
                            steady = 1'b1;
                            void'(pending.pop_front());
                        end
                        PK_STEADY_OFF:
                        begin
                            steady = 1'b0;
                            void'(pending.pop_front());
                        end
                        default:
                        begin
                            if (settle == 0)
                                void'(pending.pop_front());
                            else
                                scanning = 1'b0;
                        end
                    endcase
                end
                if (scanning && pending.size() > 0)
                begin
                    if (!steady && gap_left > 0)
                        gap_left--;
                    else
                    begin
                        present = 1'b1;
                        on_wire = pending.pop_front();
                        in_ch.opcode    <= on_wire.opcode;
                        in_ch.text_byte <= on_wire.text_byte;
                        in_ch.query_pos <= on_wire.query_pos;
                        if (!steady)
                        begin
                            burst_left--;
                            if (burst_left <= 0)
                            begin
                                burst_left = $urandom_range(1, 24);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                        : $urandom_range(1, 8);
                            end
                        end
                    end
                end
                in_ch.valid <= present;
            end
        end
    end

    // result side stalls on a rotating 16-bit pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            pat_left     = 0;
            pat_idx      = '0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'h0001;
                    default: stall_pat = 16'($urandom | $urandom);
                endcase
                pat_left = 64;
            end
            pat_left--;
            out_ch.ready <= stall_pat[pat_idx];
            pat_idx = pat_idx + 4'd1;
        end
    end

    always @(posedge clk)
    begin
        location_t got;
        location_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.line_number, out_ch.column_number, out_ch.past_end,
                    out_ch.overflowed};
            if (expected_locations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: line %0d col %0d past_end %0b overflowed %0b",
                             got.line, got.col, got.past, got.ovf);
            end
            else
            begin
                want = expected_locations.pop_front();
                if (got.line !== want.line || got.col !== want.col ||
                    got.past !== want.past || got.ovf !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp line %0d col %0d past %0b ovf %0b, %s",
                                 want.line, want.col, want.past, want.ovf,
                                 $sformatf("got %0d %0d %0b %0b",
                                           got.line, got.col, got.past, got.ovf));
                end
            end
        end
    end

    always @(negedge clk)
        drained = (expected_locations.size() == 0);

    initial
    begin
        #1_000_000;
        $display("line_start_index_and_lookup_top test failed");
        $finish;
    end

    initial
    begin
        int random_count;
        int nl_rate;
        int run;
        int k;
        logic [BYTE_W-1:0] b;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_BYTE;
        in_ch.text_byte = '0;
        in_ch.query_pos = '0;
        out_ch.ready    = 1'b0;
        drained         = 1'b1;
        mismatches      = 0;
        lines_closed    = 0;
        open_start      = '0;
        bytes_counted   = '0;
        overflow_seen   = 1'b0;
        gen_total       = 0;
        gen_lines       = 0;
        gen_starts.push_back(0);

        // directed: empty source, byte extremes, empty line, unused opcode, clear
        push_request(OP_QUERY, 8'h00, 20'd0);
        push_request(OP_QUERY, 8'hFF, 20'd1);
        push_request(OP_QUERY, 8'h00, POS_LIMIT);
        push_request(OP_BYTE, 8'h00, 20'd0);
        push_request(OP_BYTE, 8'hFF, POS_LIMIT);
        push_request(OP_BYTE, NEWLINE_BYTE, 20'd0);
        push_request(OP_BYTE, NEWLINE_BYTE, 20'd0);
        push_request(OP_BYTE, 8'h61, 20'd0);
        for (k = 0; k <= 6; k++)
            push_request(OP_QUERY, 8'h00, k[QPOS_W-1:0]);
        push_request(OP_UNUSED, 8'hFF, POS_LIMIT);
        push_request(OP_UNUSED, 8'h00, 20'd0);
        push_request(OP_QUERY, 8'h00, POS_LIMIT);
        push_request(OP_CLEAR, 8'hFF, POS_LIMIT);
        push_request(OP_QUERY, 8'h00, 20'd0);
        push_request(OP_QUERY, 8'h00, 20'd3);
        push_request(OP_BYTE, NEWLINE_BYTE, 20'd0);
        push_request(OP_QUERY, 8'h00, 20'd1);
        push_marker(PK_DRAIN);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // random: short documents with varied line lengths, queries aimed at boundaries
        random_count = 0;
        while (random_count < RANDOM_GOAL)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_request(OP_CLEAR, BYTE_W'($urandom), QPOS_W'($urandom));
                random_count++;
            end
            case ($urandom_range(0, 3))
                0:       nl_rate = 2;
                1:       nl_rate = 4;
                2:       nl_rate = 12;
                default: nl_rate = 50;
            endcase
            run = $urandom_range(1, 40);
            for (k = 0; k < run; k++)
            begin
                b = ($urandom_range(0, nl_rate - 1) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom);
                push_request(OP_BYTE, b, QPOS_W'($urandom));
            end
            random_count += run;
            run = $urandom_range(1, 6);
            for (k = 0; k < run; k++)
                push_request(OP_QUERY, BYTE_W'($urandom), choose_position());
            random_count += run;
            if ($urandom_range(0, 19) == 0)
                push_request(OP_UNUSED, BYTE_W'($urandom), QPOS_W'($urandom));
            if ($urandom_range(0, 39) == 0)
                push_marker(PK_DRAIN);
        end
        push_marker(PK_DRAIN);

        // back-to-back run with no idle gaps on the request side
        push_marker(PK_STEADY_ON);
        push_request(OP_CLEAR, 8'h00, 20'd0);
        for (k = 0; k < 48; k++)
        begin
            b = ($urandom_range(0, 3) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom);
            push_request(OP_BYTE, b, QPOS_W'($urandom));
        end
        for (k = 0; k < 6; k++)
            push_request(OP_QUERY, BYTE_W'($urandom), choose_position());
        push_marker(PK_STEADY_OFF);
        push_request(OP_QUERY, 8'h00, gen_total[QPOS_W-1:0]);
        push_request(OP_CLEAR, 8'h00, 20'd0);
        push_request(OP_BYTE, NEWLINE_BYTE, 20'd0);
        push_request(OP_BYTE, 8'h41, 20'd0);
        for (k = 0; k < 4; k++)
            push_request(OP_QUERY, 8'h00, k[QPOS_W-1:0]);

        while (pending.size() != 0 || in_ch.valid || expected_locations.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        if (expected_locations.size() != 0)
        begin
            mismatches += expected_locations.size();
            $display("%0d lookup results never arrived", expected_locations.size());
        end

        $display("covered %0d queries (%0d past end, %0d with overflow set),",
                 n_queries, n_past, n_ovf);
        $display("%0d bytes and %0d clears under bursty and stalled traffic",
                 n_bytes, n_clears);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("line_start_index_and_lookup_top test passed");
        else
            $display("line_start_index_and_lookup_top test failed");
        $finish;
    end

endmodule
